>>> rtl/epfc_pkg.sv
// Shared constants and types for the four-channel ESC pulse controller.
package epfc_pkg;

  // Default channel count
  localparam int CHANNELS_DEF = 4;

  // Field widths
  localparam int OPCODE_W = 3;
  localparam int MOTOR_W  = 2;
  localparam int PULSE_W  = 16;
  localparam int THR_W    = 16;
  localparam int HOLD_W   = 26;
  localparam int REG_W    = 3;

  // Command opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_PULSE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_THR   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ARM       = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DISARM    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_STOP      = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_CAL       = 3'd6;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_PERIOD   = 3'd0;
  localparam logic [REG_W-1:0] REG_MIN      = 3'd1;
  localparam logic [REG_W-1:0] REG_MAX      = 3'd2;
  localparam logic [REG_W-1:0] REG_IDLE     = 3'd3;
  localparam logic [REG_W-1:0] REG_ARM      = 3'd4;
  localparam logic [REG_W-1:0] REG_ARM_HOLD = 3'd5;
  localparam logic [REG_W-1:0] REG_CAL_HOLD = 3'd6;

  // Register reset values
  localparam logic [PULSE_W-1:0] PERIOD_RST   = 16'd2499;
  localparam logic [PULSE_W-1:0] MIN_RST      = 16'd1000;
  localparam logic [PULSE_W-1:0] MAX_RST      = 16'd2000;
  localparam logic [PULSE_W-1:0] IDLE_RST     = 16'd1000;
  localparam logic [PULSE_W-1:0] ARM_RST      = 16'd700;
  localparam logic [HOLD_W-1:0]  ARM_HOLD_RST = 26'd2000000;
  localparam logic [HOLD_W-1:0]  CAL_HOLD_RST = 26'd3000000;
  localparam logic [PULSE_W-1:0] COMPARE_RST  = 16'd1000;

  // Q12 full-scale throttle
  localparam logic [12:0] Q12_ONE = 13'd4096;

  // Sequence phase
  typedef enum logic [3:0] {
    PH_NONE    = 4'b0001,
    PH_ARM     = 4'b0010,
    PH_CAL_MAX = 4'b0100,
    PH_CAL_MIN = 4'b1000
  } phase_t;

endpackage

>>> rtl/epfc_if.sv
// Valid/ready channel interfaces: command, result and configuration write.
interface epfc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [epfc_pkg::OPCODE_W-1:0]       opcode;
  logic [epfc_pkg::MOTOR_W-1:0]        motor_index;
  logic [epfc_pkg::PULSE_W-1:0]        pulse_width;
  logic signed [epfc_pkg::THR_W-1:0]   throttle_q12;

  modport source (output valid, opcode, motor_index, pulse_width, throttle_q12, input ready);
  modport sink   (input valid, opcode, motor_index, pulse_width, throttle_q12, output ready);
endinterface

interface epfc_res_if #(
  parameter int CHANNELS = epfc_pkg::CHANNELS_DEF
);
  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] pwm_levels;
  logic                armed;
  logic                busy_res;
  logic                accepted;

  modport source (output valid, pwm_levels, armed, busy_res, accepted, input ready);
  modport sink   (input valid, pwm_levels, armed, busy_res, accepted, output ready);
endinterface

interface epfc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [epfc_pkg::REG_W-1:0]    index;
  logic [epfc_pkg::HOLD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/esc_pwm_four_channel_controller_top.sv
// ESC pulse controller: shared PWM counter, compare preload, arm and calibration sequencing.
//
// Usage:
//   cmd : one command beat per item (tick, set pulse, set throttle, arm, disarm,
//         stop all, calibrate). A tick beat advances the PWM counter by one.
//   res : exactly one result beat per command beat, in order: channel levels,
//         armed, busy and whether the command took effect.
//   cfg : register writes (period, pulse limits, hold times); always ready.
//         Write only while no result is outstanding.
// Result: a beat's result is registered in the output register, or in the skid
//   register while it is held. Throughput: one command per cycle while cmd.ready
//   is high, set by the single registered update of counter, compares, sequencer.
// Stall: a two-entry output stage (output register plus skid register) lets a
//   command be taken while one result waits; cmd.ready drops only when both
//   entries are full, and results are held until res.ready.
// Reset: registers return to their defaults, all compares to 1000 ticks,
//   counter and hold timer to zero, disarmed, no sequence, no results held.
module esc_pwm_four_channel_controller_top #(
  parameter int CHANNELS = epfc_pkg::CHANNELS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  epfc_cmd_if.sink      cmd,
  epfc_res_if.source    res,
  epfc_cfg_if.sink      cfg
);

  localparam int PW = epfc_pkg::PULSE_W;
  localparam int HW = epfc_pkg::HOLD_W;

  // Configuration registers
  logic [PW-1:0] period_ticks;
  logic [PW-1:0] min_pulse;
  logic [PW-1:0] max_pulse;
  logic [PW-1:0] idle_pulse;
  logic [PW-1:0] arm_pulse;
  logic [HW-1:0] arm_hold_ticks;
  logic [HW-1:0] cal_hold_ticks;

  // Controller state
  logic [PW-1:0]          tick_count, tick_count_next;
  logic [PW-1:0]          pending_compare [CHANNELS];
  logic [PW-1:0]          pending_compare_next [CHANNELS];
  logic [PW-1:0]          active_compare [CHANNELS];
  logic [PW-1:0]          active_compare_next [CHANNELS];
  logic                   armed_flag, armed_flag_next;
  epfc_pkg::phase_t       phase, phase_next;
  logic [HW-1:0]          hold_count, hold_count_next;

  // Output stage
  logic                   out_valid;
  logic [CHANNELS-1:0]    out_levels;
  logic                   out_armed;
  logic                   out_busy;
  logic                   out_acc;
  logic                   skid_valid;
  logic [CHANNELS-1:0]    skid_levels;
  logic                   skid_armed;
  logic                   skid_busy;
  logic                   skid_acc;

  // Per-beat datapath
  logic                   cmd_beat;
  logic                   res_beat;
  logic                   wrap;
  logic [PW-1:0]          tick_inc;
  logic [HW-1:0]          hold_dec;
  logic                   ch_hit;
  logic [CHANNELS-1:0]    ch_sel;
  logic [PW-1:0]          clamped_pulse;
  logic [12:0]            thr_clip;
  logic [PW-1:0]          span;
  logic [28:0]            thr_prod;
  logic [PW:0]            thr_sum;
  logic [PW-1:0]          thr_pulse;
  logic                   acc_cmd;
  logic [CHANNELS-1:0]    levels_next;

  assign cmd_beat  = cmd.valid && cmd.ready;
  assign res_beat  = out_valid && res.ready;
  assign cmd.ready = !skid_valid;
  assign cfg.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks   <= epfc_pkg::PERIOD_RST;
      min_pulse      <= epfc_pkg::MIN_RST;
      max_pulse      <= epfc_pkg::MAX_RST;
      idle_pulse     <= epfc_pkg::IDLE_RST;
      arm_pulse      <= epfc_pkg::ARM_RST;
      arm_hold_ticks <= epfc_pkg::ARM_HOLD_RST;
      cal_hold_ticks <= epfc_pkg::CAL_HOLD_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        epfc_pkg::REG_PERIOD:   period_ticks   <= cfg.data[PW-1:0];
        epfc_pkg::REG_MIN:      min_pulse      <= cfg.data[PW-1:0];
        epfc_pkg::REG_MAX:      max_pulse      <= cfg.data[PW-1:0];
        epfc_pkg::REG_IDLE:     idle_pulse     <= cfg.data[PW-1:0];
        epfc_pkg::REG_ARM:      arm_pulse      <= cfg.data[PW-1:0];
        epfc_pkg::REG_ARM_HOLD: arm_hold_ticks <= cfg.data;
        epfc_pkg::REG_CAL_HOLD: cal_hold_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // Counter, hold timer and channel select
  assign wrap     = tick_count >= period_ticks;
  assign tick_inc = tick_count + PW'(1);
  assign hold_dec = (hold_count != '0) ? hold_count - HW'(1) : '0;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      ch_sel[i] = (32'(cmd.motor_index) == i);
    end
  end
  assign ch_hit = |ch_sel;

  // Clamp a requested pulse: the lower bound wins
  assign clamped_pulse = (cmd.pulse_width < min_pulse) ? min_pulse :
                         (cmd.pulse_width > max_pulse) ? max_pulse : cmd.pulse_width;

  // Map Q12 throttle into the min..max window
  always_comb begin
    if (cmd.throttle_q12[epfc_pkg::THR_W-1]) begin
      thr_clip = '0;
    end else if (cmd.throttle_q12[14:12] != 3'd0) begin
      thr_clip = epfc_pkg::Q12_ONE;
    end else begin
      thr_clip = {1'b0, cmd.throttle_q12[11:0]};
    end
  end
  assign span      = (max_pulse > min_pulse) ? max_pulse - min_pulse : '0;
  assign thr_prod  = 29'(thr_clip) * 29'(span);
  assign thr_sum   = {1'b0, min_pulse} + thr_prod[28:12];
  assign thr_pulse = thr_sum[PW-1:0];

  // Next state for one command beat
  always_comb begin
    tick_count_next      = tick_count;
    active_compare_next  = active_compare;
    pending_compare_next = pending_compare;
    armed_flag_next      = armed_flag;
    phase_next           = phase;
    hold_count_next      = hold_count;
    acc_cmd              = 1'b0;
    if (cmd.opcode == epfc_pkg::OP_TICK) begin
      // Advance the counter; load compares at the wrap
      if (wrap) begin
        tick_count_next     = '0;
        active_compare_next = pending_compare;
      end else begin
        tick_count_next = tick_inc;
      end
      // Advance a running sequence
      if (phase != epfc_pkg::PH_NONE) begin
        hold_count_next = hold_dec;
        if (hold_dec == '0) begin
          case (phase)
            epfc_pkg::PH_ARM: begin
              for (int i = 0; i < CHANNELS; i++) pending_compare_next[i] = idle_pulse;
              armed_flag_next = 1'b1;
              phase_next      = epfc_pkg::PH_NONE;
            end
            epfc_pkg::PH_CAL_MAX: begin
              for (int i = 0; i < CHANNELS; i++) pending_compare_next[i] = min_pulse;
              hold_count_next = cal_hold_ticks;
              phase_next      = epfc_pkg::PH_CAL_MIN;
            end
            epfc_pkg::PH_CAL_MIN: begin
              for (int i = 0; i < CHANNELS; i++) pending_compare_next[i] = idle_pulse;
              phase_next = epfc_pkg::PH_NONE;
            end
            default: ;
          endcase
        end
      end
    end else if (phase == epfc_pkg::PH_NONE) begin
      case (cmd.opcode)
        epfc_pkg::OP_SET_PULSE: begin
          if (armed_flag && ch_hit) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (ch_sel[i]) pending_compare_next[i] = clamped_pulse;
            end
            acc_cmd = 1'b1;
          end
        end
        epfc_pkg::OP_SET_THR: begin
          if (armed_flag && ch_hit) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (ch_sel[i]) pending_compare_next[i] = thr_pulse;
            end
            acc_cmd = 1'b1;
          end
        end
        epfc_pkg::OP_ARM: begin
          for (int i = 0; i < CHANNELS; i++) pending_compare_next[i] = arm_pulse;
          hold_count_next = arm_hold_ticks;
          phase_next      = epfc_pkg::PH_ARM;
          acc_cmd         = 1'b1;
        end
        epfc_pkg::OP_DISARM: begin
          for (int i = 0; i < CHANNELS; i++) pending_compare_next[i] = idle_pulse;
          armed_flag_next = 1'b0;
          acc_cmd         = 1'b1;
        end
        epfc_pkg::OP_STOP: begin
          for (int i = 0; i < CHANNELS; i++) pending_compare_next[i] = idle_pulse;
          acc_cmd = 1'b1;
        end
        epfc_pkg::OP_CAL: begin
          for (int i = 0; i < CHANNELS; i++) pending_compare_next[i] = max_pulse;
          hold_count_next = cal_hold_ticks;
          phase_next      = epfc_pkg::PH_CAL_MAX;
          acc_cmd         = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Channel levels after this beat
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      levels_next[i] = tick_count_next < active_compare_next[i];
    end
  end

  // Commit state on a command beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pending_compare[i] <= epfc_pkg::COMPARE_RST;
        active_compare[i]  <= epfc_pkg::COMPARE_RST;
      end
      armed_flag <= 1'b0;
      phase      <= epfc_pkg::PH_NONE;
      hold_count <= '0;
    end else if (cmd_beat) begin
      tick_count      <= tick_count_next;
      pending_compare <= pending_compare_next;
      active_compare  <= active_compare_next;
      armed_flag      <= armed_flag_next;
      phase           <= phase_next;
      hold_count      <= hold_count_next;
    end
  end

  // Output register and skid register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_beat) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= cmd_beat;
      end
    end else if (cmd_beat) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // Result payloads: refill from skid or load the new beat
  always_ff @(posedge clk) begin
    if (res_beat && skid_valid) begin
      out_levels <= skid_levels;
      out_armed  <= skid_armed;
      out_busy   <= skid_busy;
      out_acc    <= skid_acc;
    end else if (cmd_beat && (res_beat || !out_valid)) begin
      out_levels <= levels_next;
      out_armed  <= armed_flag_next;
      out_busy   <= (phase_next != epfc_pkg::PH_NONE);
      out_acc    <= acc_cmd;
    end
    if (cmd_beat && out_valid && !res_beat) begin
      skid_levels <= levels_next;
      skid_armed  <= armed_flag_next;
      skid_busy   <= (phase_next != epfc_pkg::PH_NONE);
      skid_acc    <= acc_cmd;
    end
  end

  assign res.valid      = out_valid;
  assign res.pwm_levels = out_levels;
  assign res.armed      = out_armed;
  assign res.busy_res   = out_busy;
  assign res.accepted   = out_acc;

  // Skid register is only filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // Armed is set only by the end of the arm hold
  a_armed_from_arm: assert property (@(posedge clk) disable iff (rst)
    $rose(armed_flag) |-> ($past(phase) == epfc_pkg::PH_ARM))
    else $error("armed set outside the arm sequence");

  // Hold timer is clear whenever no sequence runs
  a_idle_hold_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == epfc_pkg::PH_NONE) |-> (hold_count == '0))
    else $error("hold timer nonzero with no sequence running");

endmodule

>>> sim/esc_pwm_four_channel_controller_top_tb.sv
// Self-checking testbench for the four-channel ESC pulse controller: predicts every result beat.
import epfc_pkg::*;

typedef struct packed {
  logic [OPCODE_W-1:0]     opcode;
  logic [MOTOR_W-1:0]      motor;
  logic [PULSE_W-1:0]      pw;
  logic signed [THR_W-1:0] thr;
} esc_cmd_t;

typedef struct packed {
  logic [CHANNELS_DEF-1:0] levels;
  logic                    armed;
  logic                    busy;
  logic                    took;
} esc_status_t;

typedef struct {
  logic [PULSE_W-1:0] period;
  logic [PULSE_W-1:0] min_pw;
  logic [PULSE_W-1:0] max_pw;
  logic [PULSE_W-1:0] idle_pw;
  logic [PULSE_W-1:0] arm_pw;
  logic [HOLD_W-1:0]  arm_hold;
  logic [HOLD_W-1:0]  cal_hold;
} esc_setting_t;

// Pulse generator shadow: tracks counter, compares and sequencer, queues expected status
class esc_pulse_scoreboard;
  logic [PULSE_W-1:0] period, min_pw, max_pw, idle_pw, arm_pw;
  logic [HOLD_W-1:0]  arm_hold, cal_hold;
  logic [PULSE_W-1:0] count;
  logic [PULSE_W-1:0] next_cmp [CHANNELS_DEF];
  logic [PULSE_W-1:0] live_cmp [CHANNELS_DEF];
  bit                 armed_now;
  phase_t             phase;
  logic [HOLD_W-1:0]  hold_left;
  esc_status_t        status_q[$];
  int errors, n_cmds, n_taken, n_checked, n_arms, n_cals, n_wraps, n_writes;

  function new();
    period = PERIOD_RST; min_pw = MIN_RST; max_pw = MAX_RST;
    idle_pw = IDLE_RST; arm_pw = ARM_RST;
    arm_hold = ARM_HOLD_RST; cal_hold = CAL_HOLD_RST;
    count = '0;
    foreach (next_cmp[i]) begin
      next_cmp[i] = COMPARE_RST;
      live_cmp[i] = COMPARE_RST;
    end
    armed_now = 0;
    phase = PH_NONE;
    hold_left = '0;
  endfunction

  function void load_all(logic [PULSE_W-1:0] v);
    foreach (next_cmp[i]) next_cmp[i] = v;
  endfunction

  function void write_reg(logic [REG_W-1:0] idx, logic [HOLD_W-1:0] d);
    n_writes++;
    case (idx)
      REG_PERIOD:   period = d[PULSE_W-1:0];
      REG_MIN:      min_pw = d[PULSE_W-1:0];
      REG_MAX:      max_pw = d[PULSE_W-1:0];
      REG_IDLE:     idle_pw = d[PULSE_W-1:0];
      REG_ARM:      arm_pw = d[PULSE_W-1:0];
      REG_ARM_HOLD: arm_hold = d;
      REG_CAL_HOLD: cal_hold = d;
      default: ;
    endcase
  endfunction

  // Advance the counter one tick, preload compares on wrap, step the sequence timer
  function void advance_tick();
    if (count >= period) begin
      count = '0;
      foreach (live_cmp[i]) live_cmp[i] = next_cmp[i];
      n_wraps++;
    end else begin
      count = count + 1'b1;
    end
    if (phase != PH_NONE) begin
      if (hold_left != 0) hold_left--;
      if (hold_left == 0) begin
        case (phase)
          PH_ARM: begin
            load_all(idle_pw);
            armed_now = 1;
            phase = PH_NONE;
            n_arms++;
          end
          PH_CAL_MAX: begin
            load_all(min_pw);
            hold_left = cal_hold;
            phase = PH_CAL_MIN;
          end
          default: begin
            load_all(idle_pw);
            phase = PH_NONE;
            n_cals++;
          end
        endcase
      end
    end
  endfunction

  function logic [PULSE_W-1:0] clamp(logic [PULSE_W-1:0] p);
    if (p < min_pw) return min_pw;
    if (p > max_pw) return max_pw;
    return p;
  endfunction

  // Note an accepted command beat and queue the status it should produce
  function void note_command(esc_cmd_t c);
    bit          took;
    int          t;
    int unsigned span;
    esc_status_t want;
    took = 0;
    n_cmds++;
    if (c.opcode == OP_TICK) begin
      advance_tick();
    end else if (phase == PH_NONE) begin
      case (c.opcode)
        OP_SET_PULSE: if (armed_now && c.motor < CHANNELS_DEF) begin
          next_cmp[c.motor] = clamp(c.pw);
          took = 1;
        end
        OP_SET_THR: if (armed_now && c.motor < CHANNELS_DEF) begin
          t = $signed(c.thr);
          if (t < 0) t = 0;
          if (t > int'(Q12_ONE)) t = Q12_ONE;
          span = (max_pw > min_pw) ? int'(max_pw) - int'(min_pw) : 0;
          next_cmp[c.motor] = PULSE_W'(min_pw + ((int'(t) * span) >> 12));
          took = 1;
        end
        OP_ARM: begin
          load_all(arm_pw);
          hold_left = arm_hold;
          phase = PH_ARM;
          took = 1;
        end
        OP_DISARM: begin
          armed_now = 0;
          load_all(idle_pw);
          took = 1;
        end
        OP_STOP: begin
          load_all(idle_pw);
          took = 1;
        end
        OP_CAL: begin
          load_all(max_pw);
          hold_left = cal_hold;
          phase = PH_CAL_MAX;
          took = 1;
        end
        default: ;
      endcase
    end
    if (took) n_taken++;
    foreach (live_cmp[i]) want.levels[i] = count < live_cmp[i];
    want.armed = armed_now;
    want.busy = phase != PH_NONE;
    want.took = took;
    status_q.push_back(want);
  endfunction

  // Compare a result beat against the oldest expectation
  function void check_result(esc_status_t got);
    esc_status_t want;
    if (status_q.size() == 0) begin
      $error("result beat with nothing expected: levels %h armed %b busy %b accepted %b",
             got.levels, got.armed, got.busy, got.took);
      errors++;
      return;
    end
    want = status_q.pop_front();
    n_checked++;
    if (got.levels !== want.levels) begin
      $error("pwm_levels: expected %h, got %h", want.levels, got.levels);
      errors++;
    end
    if (got.armed !== want.armed) begin
      $error("armed: expected %b, got %b", want.armed, got.armed);
      errors++;
    end
    if (got.busy !== want.busy) begin
      $error("busy_res: expected %b, got %b", want.busy, got.busy);
      errors++;
    end
    if (got.took !== want.took) begin
      $error("accepted: expected %b, got %b", want.took, got.took);
      errors++;
    end
  endfunction

  function int outstanding();
    return status_q.size();
  endfunction
endclass

module esc_pwm_four_channel_controller_top_tb;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
  localparam int PHASES     = 8;
  localparam int PHASE_CMDS = 170;
  localparam int QUIET_MAX  = 2000;
  localparam int CHOKE_LEN  = 64;

  logic clk;
  logic rst;
  bit   steady;
  bit   choke_req;
  int   quiet;

  esc_pulse_scoreboard sb;

  epfc_cmd_if                             cmd_bus ();
  epfc_res_if #(.CHANNELS(CHANNELS_DEF)) res_bus ();
  epfc_cfg_if                             cfg_bus ();

  esc_pwm_four_channel_controller_top #(.CHANNELS(CHANNELS_DEF)) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  // Free-running clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Check every result beat
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      sb.check_result({res_bus.pwm_levels, res_bus.armed, res_bus.busy_res, res_bus.accepted});
  end

  // Watchdog: count cycles without any beat on any channel
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("Timeout: no beat for %0d cycles", QUIET_MAX);
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    res_bus.ready = 0;
    forever begin
      @(negedge clk);
      if (choke_req) begin
        choke_req = 0;
        stall_left = CHOKE_LEN;
      end
      if (stall_left > 0) begin
        res_bus.ready = 0;
        stall_left--;
      end else begin
        res_bus.ready = steady || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  function automatic esc_cmd_t mk(logic [OPCODE_W-1:0] op, int motor, int pw, int thr);
    esc_cmd_t c;
    c.opcode = op;
    c.motor = MOTOR_W'(motor);
    c.pw = PULSE_W'(pw);
    c.thr = THR_W'(thr);
    return c;
  endfunction

  // Mostly ticks so sequences finish; commands get small pulses and edge throttles
  function automatic esc_cmd_t random_command();
    esc_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 52)      c.opcode = OP_TICK;
    else if (r < 66) c.opcode = OP_SET_PULSE;
    else if (r < 78) c.opcode = OP_SET_THR;
    else if (r < 84) c.opcode = OP_ARM;
    else if (r < 88) c.opcode = OP_DISARM;
    else if (r < 92) c.opcode = OP_STOP;
    else if (r < 97) c.opcode = OP_CAL;
    else             c.opcode = OP_UNUSED;
    c.motor = MOTOR_W'($urandom_range(0, 3));
    c.pw = ($urandom_range(0, 9) < 7) ? PULSE_W'($urandom_range(0, 80)) : PULSE_W'($urandom);
    r = $urandom_range(0, 9);
    if (r < 4)       c.thr = THR_W'($urandom_range(0, 4096));
    else if (r == 4) c.thr = THR_W'(int'($urandom_range(0, 16)) - 8);
    else if (r == 5) c.thr = THR_W'(4088 + int'($urandom_range(0, 16)));
    else             c.thr = THR_W'($urandom);
    return c;
  endfunction

  // Offer one command beat, with random idle cycles ahead of it
  task automatic drive_command(esc_cmd_t c);
    while (!steady && $urandom_range(0, 99) < 13) begin
      cmd_bus.valid = 0;
      @(negedge clk);
    end
    cmd_bus.valid = 1;
    cmd_bus.opcode = c.opcode;
    cmd_bus.motor_index = c.motor;
    cmd_bus.pulse_width = c.pw;
    cmd_bus.throttle_q12 = c.thr;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_command(c);
    @(negedge clk);
  endtask

  // Hold the command side until every expected result has arrived
  task automatic drain();
    cmd_bus.valid = 0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [REG_W-1:0] idx, logic [HOLD_W-1:0] d);
    cfg_bus.valid = 1;
    cfg_bus.index = idx;
    cfg_bus.data = d;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  // Pick and write the register setting for one phase of the run
  task automatic apply_setting(int ph);
    esc_setting_t s;
    case (ph)
      0: s = '{29, 10, 20, 12, 5, 2, 2};
      1: s = '{0, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0};
      2: s = '{7, 6, 3, 2, 8, 5, 1};
      3: s = '{16'hFFFF, 0, 0, 16'hFFFF, 0, 10, 6};
      7: s = '{3, $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5),
               $urandom_range(0, 5), 26'h3FFFFFF, 26'h3FFFFFF};
      default: s = '{$urandom_range(1, 40), $urandom_range(0, 30), $urandom_range(0, 50),
                     $urandom_range(0, 40), $urandom_range(0, 40),
                     $urandom_range(0, 25), $urandom_range(0, 25)};
    endcase
    write_register(REG_PERIOD, HOLD_W'(s.period));
    write_register(REG_MIN, HOLD_W'(s.min_pw));
    write_register(REG_MAX, HOLD_W'(s.max_pw));
    write_register(REG_IDLE, HOLD_W'(s.idle_pw));
    write_register(REG_ARM, HOLD_W'(s.arm_pw));
    write_register(REG_ARM_HOLD, s.arm_hold);
    write_register(REG_CAL_HOLD, s.cal_hold);
    cfg_bus.valid = 0;
  endtask

  // Directed walk: disarmed and busy rejects, clamps, throttle ends, re-arm, calibration
  task automatic run_directed();
    drive_command(mk(OP_SET_PULSE, 3, 15, 0));
    drive_command(mk(OP_SET_THR, 2, 0, 2048));
    drive_command(mk(OP_UNUSED, 1, 16'hFFFF, -1));
    drive_command(mk(OP_TICK, 0, 0, 0));
    drive_command(mk(OP_ARM, 0, 0, 0));
    drive_command(mk(OP_SET_PULSE, 0, 15, 0));
    repeat (2) drive_command(mk(OP_TICK, 3, 16'hFFFF, 16'h7FFF));
    drive_command(mk(OP_SET_PULSE, 0, 0, 0));
    drive_command(mk(OP_SET_PULSE, 1, 16'hFFFF, 0));
    drive_command(mk(OP_SET_PULSE, 2, 15, 0));
    drive_command(mk(OP_SET_THR, 3, 0, -32768));
    drive_command(mk(OP_SET_THR, 0, 0, 32767));
    drive_command(mk(OP_SET_THR, 1, 0, 2048));
    drive_command(mk(OP_SET_THR, 2, 0, 4096));
    drive_command(mk(OP_ARM, 0, 0, 0));
    repeat (2) drive_command(mk(OP_TICK, 0, 0, 0));
    drive_command(mk(OP_STOP, 0, 0, 0));
    drive_command(mk(OP_CAL, 0, 0, 0));
    drive_command(mk(OP_DISARM, 0, 0, 0));
    repeat (4) drive_command(mk(OP_TICK, 0, 0, 0));
    drive_command(mk(OP_DISARM, 0, 0, 0));
  endtask

  // Stimulus: reset, then one register setting per phase with random commands
  initial begin
    sb = new();
    rst = 1;
    steady = 0;
    choke_req = 0;
    quiet = 0;
    cmd_bus.valid = 0;
    cmd_bus.opcode = OP_TICK;
    cmd_bus.motor_index = '0;
    cmd_bus.pulse_width = '0;
    cmd_bus.throttle_q12 = '0;
    cfg_bus.valid = 0;
    cfg_bus.index = REG_PERIOD;
    cfg_bus.data = '0;
    repeat (6) @(negedge clk);
    rst = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      steady = (ph == 5);
      apply_setting(ph);
      if (ph == 0) run_directed();
      for (int k = 0; k < PHASE_CMDS; k++) begin
        // choke the result side while commands keep coming
        if ((ph == 2 || ph == 6) && k == 20) choke_req = 1;
        if (k == PHASE_CMDS / 2) drain();
        drive_command(random_command());
      end
    end
    drain();
    repeat (10) @(negedge clk);
    $display("Drove %0d commands (%0d took effect) across %0d register writes; %0d results checked.",
             sb.n_cmds, sb.n_taken, sb.n_writes, sb.n_checked);
    $display("Finished %0d arm and %0d calibration sequences; counter wrapped %0d times.",
             sb.n_arms, sb.n_cals, sb.n_wraps);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
